FILE: hdl/bclp_pkg.sv
// Package for the button click / long press detector.
// Holds the state and event codes, register indexes, register reset values and the
// configuration struct. It depends on nothing else.
package bclp_pkg;

  // Widths of the configuration registers and of the configuration port.
  localparam int unsigned DEBOUNCE_W = 20;
  localparam int unsigned LONG_W     = 26;
  localparam int unsigned REPEAT_W   = 24;
  localparam int unsigned CLICK_W    = 24;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  // Register reset values, in microseconds.
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(20000);
  localparam logic [LONG_W-1:0]     LONG_RESET     = LONG_W'(1000000);
  localparam logic [REPEAT_W-1:0]   REPEAT_RESET   = REPEAT_W'(500000);
  localparam logic [CLICK_W-1:0]    CLICK_RESET    = CLICK_W'(50000);

  // Machine states as reported on the result channel.
  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_RELEASED = 2'd2,
    ST_WAIT_REL = 2'd3
  } state_t;

  // Event codes.
  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_CLICK    = 2'd1,
    EV_LONG     = 2'd2,
    EV_LONG_REL = 2'd3
  } event_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_REPEAT   = 2'd2,
    REG_CLICK    = 2'd3
  } reg_idx_t;

  // Current register contents, handed from the register file to the step logic.
  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_time_us;
    logic [LONG_W-1:0]     long_press_time_us;
    logic [REPEAT_W-1:0]   repeat_interval_us;
    logic [CLICK_W-1:0]    click_timeout_us;
  } cfg_t;

endpackage

FILE: hdl/bclp_if.sv
// Channel interfaces of the button click / long press detector: samples in,
// events out and configuration writes. Depends on bclp_pkg.

// Poll sample channel.
interface bclp_sample_if #(
  parameter int unsigned TIME_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic                 pin_level;
  logic [TIME_BITS-1:0] time_stamp_us;

  modport source (output valid, output pin_level, output time_stamp_us, input ready);
  modport sink   (input valid, input pin_level, input time_stamp_us, output ready);
endinterface

// Result channel.
interface bclp_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] button_event;
  logic [1:0] machine_state;

  modport source (output valid, output button_event, output machine_state, input ready);
  modport sink   (input valid, input button_event, input machine_state, output ready);
endinterface

// Configuration write channel.
interface bclp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bclp_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [bclp_pkg::CFG_DATA_W-1:0]  wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

FILE: hdl/bclp_cfg.sv
// Configuration register file of the button click / long press detector.
// Depends on bclp_pkg and bclp_if.
module bclp_cfg (
  input  logic             clk,
  input  logic             rst,
  bclp_cfg_if.sink         cfg,
  output bclp_pkg::cfg_t   regs
);

  bclp_pkg::reg_idx_t idx;

  // Writes are always taken.
  assign cfg.ready = 1'b1;
  assign idx       = bclp_pkg::reg_idx_t'(cfg.reg_index);

  // Register write; only the low bits of the data word are kept.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_time_us   <= bclp_pkg::DEBOUNCE_RESET;
      regs.long_press_time_us <= bclp_pkg::LONG_RESET;
      regs.repeat_interval_us <= bclp_pkg::REPEAT_RESET;
      regs.click_timeout_us   <= bclp_pkg::CLICK_RESET;
    end else if (cfg.valid) begin
      unique case (idx)
        bclp_pkg::REG_DEBOUNCE:
          regs.debounce_time_us <= cfg.wr_data[bclp_pkg::DEBOUNCE_W-1:0];
        bclp_pkg::REG_LONG:
          regs.long_press_time_us <= cfg.wr_data[bclp_pkg::LONG_W-1:0];
        bclp_pkg::REG_REPEAT:
          regs.repeat_interval_us <= cfg.wr_data[bclp_pkg::REPEAT_W-1:0];
        bclp_pkg::REG_CLICK:
          regs.click_timeout_us <= cfg.wr_data[bclp_pkg::CLICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/bclp_step.sv
// Per-sample logic of the button click / long press detector: debounce timer,
// press state machine and event selection. Depends on bclp_pkg.
module bclp_step #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   pin_level,
  input  logic [TIME_BITS-1:0]   now,
  input  bclp_pkg::cfg_t         regs,
  output bclp_pkg::event_t       button_event,
  output bclp_pkg::state_t       machine_state
);

  bclp_pkg::state_t     state, state_next, st1, st2;
  logic                 last_level, long_fired, click_pend;
  logic [TIME_BITS-1:0] deb_start, press_start, release_at, repeat_at;
  logic [TIME_BITS-1:0] deb_start_next, press_start_next, release_at_next, repeat_at_next;
  logic                 long_fired_next, click_pend_next;
  logic                 lf1, cp1, lf2, cp2;
  logic                 pressed, changed, stable;
  logic                 br_press, br_release, br_long_rel;
  logic                 long_hit, rep_hit, click_hit, restart;
  logic [TIME_BITS-1:0] e_deb, e_press, e_repeat, e_release;

  assign pressed = ~pin_level;
  assign changed = pressed != last_level;

  // Elapsed times; a timer restarted by this very sample reads zero.
  assign e_deb     = changed ? '0 : now - deb_start;
  assign stable    = e_deb >= TIME_BITS'(regs.debounce_time_us);
  assign e_press   = br_press ? '0 : now - press_start;
  assign e_repeat  = long_hit ? '0 : now - repeat_at;
  assign e_release = br_release ? '0 : now - release_at;

  // Debounced level changes acting on the machine.
  assign br_press    = stable && state == bclp_pkg::ST_IDLE && pressed;
  assign br_release  = stable && state == bclp_pkg::ST_PRESSED && !pressed;
  assign br_long_rel = stable && state == bclp_pkg::ST_WAIT_REL && !pressed;

  // Timer checks in the order they take effect within one sample.
  assign long_hit  = st1 == bclp_pkg::ST_PRESSED && !lf1 &&
                     e_press >= TIME_BITS'(regs.long_press_time_us);
  assign rep_hit   = st2 == bclp_pkg::ST_WAIT_REL && lf2 && pressed &&
                     e_repeat >= TIME_BITS'(regs.repeat_interval_us);
  assign click_hit = st2 == bclp_pkg::ST_IDLE && cp2 &&
                     e_release >= TIME_BITS'(regs.click_timeout_us);
  assign restart   = click_hit || br_long_rel;

  // Machine after a debounced level change.
  always_comb begin
    st1 = state;
    lf1 = long_fired;
    cp1 = click_pend;
    if (br_press) begin
      st1 = bclp_pkg::ST_PRESSED;
      lf1 = 1'b0;
      cp1 = 1'b1;
    end else if (br_release) begin
      st1 = long_fired ? bclp_pkg::ST_RELEASED : bclp_pkg::ST_IDLE;
    end else if (br_long_rel) begin
      st1 = bclp_pkg::ST_IDLE;
      lf1 = 1'b0;
      cp1 = 1'b0;
    end
  end

  // Machine after the first long press check.
  assign st2 = long_hit ? bclp_pkg::ST_WAIT_REL : st1;
  assign lf2 = long_hit | lf1;
  assign cp2 = long_hit ? 1'b0 : cp1;

  // Next state and timer values.
  always_comb begin
    state_next       = restart ? bclp_pkg::ST_IDLE : st2;
    long_fired_next  = restart ? 1'b0 : lf2;
    click_pend_next  = restart ? 1'b0 : cp2;
    press_start_next = restart ? '0 : (br_press ? now : press_start);
    release_at_next  = restart ? '0 : (br_release ? now : release_at);
    repeat_at_next   = restart ? '0 : ((long_hit || rep_hit) ? now : repeat_at);
    deb_start_next   = (changed || restart) ? now : deb_start;
  end

  // Result of this sample; the last event raised wins.
  always_comb begin
    if (click_hit) begin
      button_event = bclp_pkg::EV_CLICK;
    end else if (long_hit || rep_hit) begin
      button_event = bclp_pkg::EV_LONG;
    end else if (br_long_rel) begin
      button_event = bclp_pkg::EV_LONG_REL;
    end else begin
      button_event = bclp_pkg::EV_NONE;
    end
    machine_state = state_next;
  end

  // Machine registers, updated once per processed sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= bclp_pkg::ST_IDLE;
      last_level  <= 1'b0;
      long_fired  <= 1'b0;
      click_pend  <= 1'b0;
      deb_start   <= '0;
      press_start <= '0;
      release_at  <= '0;
      repeat_at   <= '0;
    end else if (advance) begin
      state       <= state_next;
      last_level  <= pressed;
      long_fired  <= long_fired_next;
      click_pend  <= click_pend_next;
      deb_start   <= deb_start_next;
      press_start <= press_start_next;
      release_at  <= release_at_next;
      repeat_at   <= repeat_at_next;
    end
  end

endmodule

FILE: hdl/button_click_long_press_detector_unit.sv
// Button click / long press detector, top level.
// Depends on bclp_pkg, bclp_if, bclp_cfg and bclp_step.
//
// Usage:
//   samples : one poll sample per word, the raw active-low pin level and a free
//             running microsecond time stamp that wraps at TIME_BITS bits.
//   events  : exactly one word per sample, the event (none, single click,
//             long press, long release) and the machine state after it.
//   cfg     : register writes (debounce, long press, repeat, click timeout),
//             always taken at once; write only while no sample is in flight.
// A sample passes the sample register, then the result register, to events.
// Throughput: one sample per cycle unless stalled; the whole per-sample
// update is a single pass of compare and subtract logic between the sample
// and result registers, fed back into the machine state the same cycle.
// Stalls: while events.ready is low the result register holds and one further
// sample is still taken into the sample register, after which samples.ready
// drops until the result is taken.
// Reset (rst, synchronous): machine idle, all timers zero, registers at their
// defaults, both channel registers empty.
module button_click_long_press_detector_unit #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic             clk,
  input  logic             rst,
  bclp_sample_if.sink      samples,
  bclp_event_if.source     events,
  bclp_cfg_if.sink         cfg
);

  bclp_pkg::cfg_t       regs;
  bclp_pkg::event_t     ev_next;
  bclp_pkg::state_t     st_next;
  logic                 smp_valid, smp_pin;
  logic [TIME_BITS-1:0] smp_time;
  logic                 res_valid;
  logic [1:0]           res_event, res_state;
  logic                 res_free, advance;

  // Handshake control.
  assign res_free      = !res_valid || events.ready;
  assign advance       = smp_valid && res_free;
  assign samples.ready = !smp_valid || res_free;

  bclp_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  bclp_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .pin_level     (smp_pin),
    .now           (smp_time),
    .regs          (regs),
    .button_event  (ev_next),
    .machine_state (st_next)
  );

  // Sample register.
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (samples.ready) begin
      smp_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.ready && samples.valid) begin
      smp_pin  <= samples.pin_level;
      smp_time <= samples.time_stamp_us;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= smp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_event <= 2'(ev_next);
      res_state <= 2'(st_next);
    end
  end

  assign events.valid         = res_valid;
  assign events.button_event  = res_event;
  assign events.machine_state = res_state;

endmodule

FILE: tb/tb_button_click_long_press_detector_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for button_click_long_press_detector_unit: a directed table,
// then random press and release gestures checked word by word against a behavioural
// predictor. Depends on bclp_pkg, the channel interfaces in bclp_if and the unit itself.
module tb_button_click_long_press_detector_unit;

  localparam int unsigned TIME_W       = 48;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned PHASE_ITEMS  = 130;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // One result word: the event and the machine state after it.
  typedef struct packed {
    bclp_pkg::event_t ev;
    bclp_pkg::state_t st;
  } button_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  // One row of the directed table: a poll sample or a register write.
  typedef struct {
    row_kind_t                       kind;
    logic                            pin;
    logic [TIME_W-1:0]               ts;
    bclp_pkg::reg_idx_t              idx;
    logic [bclp_pkg::CFG_DATA_W-1:0] data;
    bit                              typed;
    button_result_t                  want;
  } stim_row_t;

  localparam button_result_t NOT_TYPED = '{ev: bclp_pkg::EV_NONE, st: bclp_pkg::ST_IDLE};

  logic clk;
  logic rst;

  bclp_sample_if #(.TIME_BITS(TIME_W)) samples ();
  bclp_event_if events ();
  bclp_cfg_if cfg ();

  button_click_long_press_detector_unit #(.TIME_BITS(TIME_W)) uut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .events  (events),
    .cfg     (cfg)
  );

  // Register copies held by the predictor.
  logic [bclp_pkg::DEBOUNCE_W-1:0] deb_time    = bclp_pkg::DEBOUNCE_RESET;
  logic [bclp_pkg::LONG_W-1:0]     long_time   = bclp_pkg::LONG_RESET;
  logic [bclp_pkg::REPEAT_W-1:0]   repeat_time = bclp_pkg::REPEAT_RESET;
  logic [bclp_pkg::CLICK_W-1:0]    click_time  = bclp_pkg::CLICK_RESET;

  // Gesture state held by the predictor.
  bclp_pkg::state_t  btn_state      = bclp_pkg::ST_IDLE;
  logic              level_pressed  = 1'b0;
  logic [TIME_W-1:0] debounce_since = '0;
  logic [TIME_W-1:0] press_since    = '0;
  logic [TIME_W-1:0] released_at    = '0;
  logic [TIME_W-1:0] repeated_at    = '0;
  logic              click_armed    = 1'b0;
  logic              long_fired     = 1'b0;

  button_result_t expected_events[$];
  stim_row_t      directed_rows[$];
  int             mismatch_count = 0;
  int             sample_count = 0;
  int             burst_left = 0;
  int unsigned    cycle_count = 0;
  logic [TIME_W-1:0] now_us = '0;

  // Wrapping time difference.
  function automatic logic [TIME_W-1:0] since(input logic [TIME_W-1:0] t_now,
                                              input logic [TIME_W-1:0] t_from);
    return t_now - t_from;
  endfunction

  // Back to idle after a single click or a long release.
  function automatic void clear_gesture(input logic pressed, input logic [TIME_W-1:0] t_now);
    btn_state      = bclp_pkg::ST_IDLE;
    click_armed    = 1'b0;
    long_fired     = 1'b0;
    press_since    = '0;
    released_at    = '0;
    repeated_at    = '0;
    level_pressed  = pressed;
    debounce_since = t_now;
  endfunction

  // Register write as the unit applies it: only the low bits of the data are kept.
  function automatic void apply_register(input bclp_pkg::reg_idx_t idx,
                                         input logic [bclp_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      bclp_pkg::REG_DEBOUNCE: deb_time    = data[bclp_pkg::DEBOUNCE_W-1:0];
      bclp_pkg::REG_LONG:     long_time   = data[bclp_pkg::LONG_W-1:0];
      bclp_pkg::REG_REPEAT:   repeat_time = data[bclp_pkg::REPEAT_W-1:0];
      bclp_pkg::REG_CLICK:    click_time  = data[bclp_pkg::CLICK_W-1:0];
      default: ;
    endcase
  endfunction

  // Advances the gesture state by one poll sample and returns the word it produces.
  // Later checks overwrite the event, so the last event to fire is the one reported.
  function automatic button_result_t predict_button_event(input logic pin,
                                                          input logic [TIME_W-1:0] t_now);
    logic pressed;
    button_result_t r;
    pressed = ~pin;
    r.ev = bclp_pkg::EV_NONE;
    if (pressed != level_pressed) begin
      debounce_since = t_now;
      level_pressed  = pressed;
    end
    if (since(t_now, debounce_since) >= TIME_W'(deb_time)) begin
      if (btn_state == bclp_pkg::ST_IDLE && pressed) begin
        btn_state   = bclp_pkg::ST_PRESSED;
        press_since = t_now;
        click_armed = 1'b1;
        long_fired  = 1'b0;
      end else if (btn_state == bclp_pkg::ST_PRESSED && !pressed) begin
        released_at = t_now;
        btn_state   = long_fired ? bclp_pkg::ST_RELEASED : bclp_pkg::ST_IDLE;
      end else if (btn_state == bclp_pkg::ST_WAIT_REL && !pressed) begin
        r.ev = bclp_pkg::EV_LONG_REL;
        clear_gesture(pressed, t_now);
      end
    end
    if (btn_state == bclp_pkg::ST_PRESSED && !long_fired &&
        since(t_now, press_since) >= TIME_W'(long_time)) begin
      long_fired  = 1'b1;
      click_armed = 1'b0;
      btn_state   = bclp_pkg::ST_WAIT_REL;
      repeated_at = t_now;
      r.ev        = bclp_pkg::EV_LONG;
    end
    if (btn_state == bclp_pkg::ST_WAIT_REL && long_fired && pressed &&
        since(t_now, repeated_at) >= TIME_W'(repeat_time)) begin
      repeated_at = t_now;
      r.ev        = bclp_pkg::EV_LONG;
    end
    if (btn_state == bclp_pkg::ST_IDLE && click_armed &&
        since(t_now, released_at) >= TIME_W'(click_time)) begin
      r.ev = bclp_pkg::EV_CLICK;
      clear_gesture(pressed, t_now);
    end
    r.st = btn_state;
    return r;
  endfunction

  function automatic void add_sample_row(input logic pin, input logic [TIME_W-1:0] ts,
                                         input bit typed, input bclp_pkg::event_t ev,
                                         input bclp_pkg::state_t st);
    stim_row_t row;
    row.kind  = ROW_SAMPLE;
    row.pin   = pin;
    row.ts    = ts;
    row.idx   = bclp_pkg::REG_DEBOUNCE;
    row.data  = '0;
    row.typed = typed;
    row.want  = '{ev: ev, st: st};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_write_row(input bclp_pkg::reg_idx_t idx,
                                        input logic [bclp_pkg::CFG_DATA_W-1:0] data);
    stim_row_t row;
    row.kind  = ROW_WRITE;
    row.pin   = 1'b1;
    row.ts    = '0;
    row.idx   = idx;
    row.data  = data;
    row.typed = 1'b0;
    row.want  = NOT_TYPED;
    directed_rows.push_back(row);
  endfunction

  // Sends one poll sample, with sender gaps between bursts, and records the word it
  // should produce: the typed one where given, else the predictor's.
  task automatic push_sample(input logic pin, input logic [TIME_W-1:0] ts,
                             input bit typed, input button_result_t want);
    int gap;
    button_result_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        samples.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    samples.valid         = 1'b1;
    samples.pin_level     = pin;
    samples.time_stamp_us = ts;
    do @(posedge clk); while (!samples.ready);
    predicted = predict_button_event(pin, ts);
    expected_events.push_back(typed ? want : predicted);
    sample_count++;
    @(negedge clk);
  endtask

  // Holds the sender until every expected word has come back.
  task automatic drain_events();
    samples.valid = 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
  endtask

  // Register write, only once the unit is idle.
  task automatic write_register(input bclp_pkg::reg_idx_t idx,
                                input logic [bclp_pkg::CFG_DATA_W-1:0] data);
    drain_events();
    cfg.valid     = 1'b1;
    cfg.reg_index = idx;
    cfg.wr_data   = data;
    do @(posedge clk); while (!cfg.ready);
    apply_register(idx, data);
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  // Writes a register, now and then with junk above its width.
  task automatic load_register(input bclp_pkg::reg_idx_t idx, input int unsigned width,
                               input logic [bclp_pkg::CFG_DATA_W-1:0] value);
    logic [bclp_pkg::CFG_DATA_W-1:0] junk;
    junk = $urandom_range(0, 1) ? (bclp_pkg::CFG_DATA_W'($urandom) << width) : '0;
    write_register(idx, value | junk);
  endtask

  // Holds one pin level for about len microseconds, with the odd contact bounce.
  task automatic hold_level(input logic pin, input longint unsigned len);
    longint unsigned spent;
    longint unsigned step;
    longint unsigned step_max;
    spent    = 0;
    step_max = len / 4 + 1;
    do begin
      if ($urandom_range(0, 11) == 0) push_sample(!pin, now_us, 1'b0, NOT_TYPED);
      push_sample(pin, now_us, 1'b0, NOT_TYPED);
      step   = 64'($urandom_range(0, 32'(step_max)));
      now_us = now_us + TIME_W'(step);
      spent  = spent + step;
    end while (spent < len);
  endtask

  // One press and release, sized from the current registers, sometimes followed by
  // samples with unrelated levels and time stamps.
  task automatic run_gesture();
    longint unsigned press_len;
    longint unsigned release_len;
    logic [TIME_W-1:0] ts;
    press_len   = 64'($urandom_range(0, 32'(2 * deb_time + long_time + 3 * repeat_time + 1)));
    release_len = 64'($urandom_range(0, 32'(2 * deb_time + 2 * click_time + 1)));
    hold_level(1'b0, press_len);
    hold_level(1'b1, release_len);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        ts = TIME_W'({$urandom, $urandom});
        push_sample(1'($urandom_range(0, 1)), ts, 1'b0, NOT_TYPED);
        now_us = ts;
      end
    end
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls: stretches of always ready, random, sparse and periodic stalls.
  int unsigned ready_mode = 0;
  int unsigned ready_mode_left = 0;
  always @(negedge clk) begin
    if (ready_mode_left == 0) begin
      ready_mode      = $urandom_range(0, 3);
      ready_mode_left = $urandom_range(20, 200);
    end else begin
      ready_mode_left = ready_mode_left - 1;
    end
    case (ready_mode)
      0:       events.ready <= 1'b1;
      1:       events.ready <= 1'($urandom_range(0, 1));
      2:       events.ready <= ($urandom_range(0, 7) != 0);
      default: events.ready <= (cycle_count % 4 == 0);
    endcase
  end

  // Result checker: every word taken is compared with the oldest expectation.
  always @(posedge clk) begin
    button_result_t want;
    if (!rst && events.valid && events.ready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: word with nothing expected: event %0d state %0d", $time,
                 events.button_event, events.machine_state);
        mismatch_count++;
      end else begin
        want = expected_events.pop_front();
        if (events.button_event !== want.ev) begin
          $display("%0t: button_event expected %0d actual %0d", $time, want.ev,
                   events.button_event);
          mismatch_count++;
        end
        if (events.machine_state !== want.st) begin
          $display("%0t: machine_state expected %0d actual %0d", $time, want.st,
                   events.machine_state);
          mismatch_count++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run limit reached with %0d words outstanding", $time,
               expected_events.size());
      $display("** button_click_long_press_detector_unit: FAILED **");
      $finish;
    end
  end

  // Stimulus.
  initial begin
    int phase_no;
    int kind;
    int phase_start;
    int directed_count;
    stim_row_t row;

    rst                   = 1'b1;
    samples.valid         = 1'b0;
    samples.pin_level     = 1'b1;
    samples.time_stamp_us = '0;
    cfg.valid             = 1'b0;
    cfg.reg_index         = bclp_pkg::REG_DEBOUNCE;
    cfg.wr_data           = '0;

    // Directed table, default registers first: click, long press with one repeat and
    // long release, then a press whose debounce spans the time stamp wrap.
    add_sample_row(1'b1, 48'd0,       1'b1, bclp_pkg::EV_NONE,  bclp_pkg::ST_IDLE);
    add_sample_row(1'b0, 48'd100,     1'b1, bclp_pkg::EV_NONE,  bclp_pkg::ST_IDLE);
    add_sample_row(1'b0, 48'd20100,   1'b1, bclp_pkg::EV_NONE,  bclp_pkg::ST_PRESSED);
    add_sample_row(1'b1, 48'd30000,   1'b1, bclp_pkg::EV_NONE,  bclp_pkg::ST_PRESSED);
    add_sample_row(1'b1, 48'd50000,   1'b1, bclp_pkg::EV_NONE,  bclp_pkg::ST_IDLE);
    add_sample_row(1'b1, 48'd100000,  1'b1, bclp_pkg::EV_CLICK, bclp_pkg::ST_IDLE);
    add_sample_row(1'b0, 48'd200000,  1'b1, bclp_pkg::EV_NONE,  bclp_pkg::ST_IDLE);
    add_sample_row(1'b0, 48'd220000,  1'b1, bclp_pkg::EV_NONE,  bclp_pkg::ST_PRESSED);
    add_sample_row(1'b0, 48'd1220000, 1'b1, bclp_pkg::EV_LONG,  bclp_pkg::ST_WAIT_REL);
    add_sample_row(1'b0, 48'd1720000, 1'b1, bclp_pkg::EV_LONG,  bclp_pkg::ST_WAIT_REL);
    add_sample_row(1'b0, 48'd1800000, 1'b1, bclp_pkg::EV_NONE,  bclp_pkg::ST_WAIT_REL);
    add_sample_row(1'b1, 48'd1800000, 1'b1, bclp_pkg::EV_NONE,  bclp_pkg::ST_WAIT_REL);
    add_sample_row(1'b1, 48'd1820000, 1'b1, bclp_pkg::EV_LONG_REL, bclp_pkg::ST_IDLE);
    add_sample_row(1'b0, 48'hFFFF_FFFF_FFF0, 1'b1, bclp_pkg::EV_NONE, bclp_pkg::ST_IDLE);
    add_sample_row(1'b0, 48'd19984,   1'b1, bclp_pkg::EV_NONE,  bclp_pkg::ST_PRESSED);
    add_sample_row(1'b1, 48'd40000,   1'b1, bclp_pkg::EV_NONE,  bclp_pkg::ST_PRESSED);
    add_sample_row(1'b1, 48'd60000,   1'b1, bclp_pkg::EV_NONE,  bclp_pkg::ST_IDLE);
    add_sample_row(1'b1, 48'd110000,  1'b1, bclp_pkg::EV_CLICK, bclp_pkg::ST_IDLE);
    // All times zero: press, long press and repeat land on one sample.
    add_write_row(bclp_pkg::REG_DEBOUNCE, '0);
    add_write_row(bclp_pkg::REG_LONG,     '0);
    add_write_row(bclp_pkg::REG_REPEAT,   '0);
    add_write_row(bclp_pkg::REG_CLICK,    '0);
    add_sample_row(1'b0, 48'd131072,  1'b0, bclp_pkg::EV_NONE,  bclp_pkg::ST_IDLE);
    add_sample_row(1'b0, 48'd131072,  1'b0, bclp_pkg::EV_NONE,  bclp_pkg::ST_IDLE);
    add_sample_row(1'b1, 48'd131073,  1'b0, bclp_pkg::EV_NONE,  bclp_pkg::ST_IDLE);
    // Oversized long press value is cut to the register; a click then fires on release.
    add_write_row(bclp_pkg::REG_LONG, 32'hFFFF_FFFF);
    add_sample_row(1'b0, 48'd196608,  1'b0, bclp_pkg::EV_NONE,  bclp_pkg::ST_IDLE);
    add_sample_row(1'b1, 48'd196613,  1'b0, bclp_pkg::EV_NONE,  bclp_pkg::ST_IDLE);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) write_register(row.idx, row.data);
      else push_sample(row.pin, row.ts, row.typed, row.want);
    end
    directed_count = sample_count;

    // Random phases, each under its own register setting.
    phase_no = 0;
    while (sample_count - directed_count < RANDOM_ITEMS) begin
      kind = (phase_no < 5) ? phase_no : $urandom_range(0, 4);
      case (kind)
        0: begin
          load_register(bclp_pkg::REG_DEBOUNCE, bclp_pkg::DEBOUNCE_W, $urandom_range(0, 8));
          load_register(bclp_pkg::REG_LONG,     bclp_pkg::LONG_W,     $urandom_range(20, 80));
          load_register(bclp_pkg::REG_REPEAT,   bclp_pkg::REPEAT_W,   $urandom_range(5, 30));
          load_register(bclp_pkg::REG_CLICK,    bclp_pkg::CLICK_W,    $urandom_range(5, 40));
        end
        1: begin
          load_register(bclp_pkg::REG_DEBOUNCE, bclp_pkg::DEBOUNCE_W,
                        $urandom_range(0, 8000));
          load_register(bclp_pkg::REG_LONG,     bclp_pkg::LONG_W,
                        $urandom_range(20000, 80000));
          load_register(bclp_pkg::REG_REPEAT,   bclp_pkg::REPEAT_W,
                        $urandom_range(5000, 30000));
          load_register(bclp_pkg::REG_CLICK,    bclp_pkg::CLICK_W,
                        $urandom_range(5000, 40000));
        end
        2: begin
          load_register(bclp_pkg::REG_DEBOUNCE, bclp_pkg::DEBOUNCE_W, 1000000);
          load_register(bclp_pkg::REG_LONG,     bclp_pkg::LONG_W,     60000000);
          load_register(bclp_pkg::REG_REPEAT,   bclp_pkg::REPEAT_W,   10000000);
          load_register(bclp_pkg::REG_CLICK,    bclp_pkg::CLICK_W,    10000000);
        end
        3: begin
          load_register(bclp_pkg::REG_DEBOUNCE, bclp_pkg::DEBOUNCE_W, 0);
          load_register(bclp_pkg::REG_LONG,     bclp_pkg::LONG_W,     $urandom_range(0, 3));
          load_register(bclp_pkg::REG_REPEAT,   bclp_pkg::REPEAT_W,   $urandom_range(0, 1));
          load_register(bclp_pkg::REG_CLICK,    bclp_pkg::CLICK_W,    $urandom_range(0, 2));
        end
        default: begin
          load_register(bclp_pkg::REG_DEBOUNCE, bclp_pkg::DEBOUNCE_W,
                        bclp_pkg::CFG_DATA_W'(bclp_pkg::DEBOUNCE_RESET));
          load_register(bclp_pkg::REG_LONG,     bclp_pkg::LONG_W,
                        bclp_pkg::CFG_DATA_W'(bclp_pkg::LONG_RESET));
          load_register(bclp_pkg::REG_REPEAT,   bclp_pkg::REPEAT_W,
                        bclp_pkg::CFG_DATA_W'(bclp_pkg::REPEAT_RESET));
          load_register(bclp_pkg::REG_CLICK,    bclp_pkg::CLICK_W,
                        bclp_pkg::CFG_DATA_W'(bclp_pkg::CLICK_RESET));
        end
      endcase
      // Some phases start just short of the time stamp wrap.
      if ($urandom_range(0, 2) == 0) begin
        now_us = '1 - TIME_W'($urandom_range(0, 32'(long_time) + 100));
      end else begin
        now_us = TIME_W'({$urandom, $urandom});
      end
      phase_start = sample_count;
      while (sample_count - phase_start < PHASE_ITEMS &&
             sample_count - directed_count < RANDOM_ITEMS) begin
        run_gesture();
      end
      phase_no++;
    end

    // Wait for the last words, then allow the unit's latency before the verdict.
    drain_events();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("** button_click_long_press_detector_unit: PASSED **");
    end else begin
      $display("** button_click_long_press_detector_unit: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/bclp_pkg.sv
hdl/bclp_if.sv
hdl/bclp_cfg.sv
hdl/bclp_step.sv
hdl/button_click_long_press_detector_unit.sv
tb/tb_button_click_long_press_detector_unit.sv
